### hdl/bftm_pkg.sv
package bftm_pkg;

  localparam int DEF_TAPE_DEPTH    = 65536;
  localparam int DEF_PROGRAM_DEPTH = 4096;
  localparam int DEF_STACK_DEPTH   = 256;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_STEP   = 2'd3;

  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_IN    = 8'h2C;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_PTR_HIGH     = 3'd1;
  localparam logic [2:0] ERR_PTR_LOW      = 3'd2;
  localparam logic [2:0] ERR_UNMATCHED_CL = 3'd3;
  localparam logic [2:0] ERR_UNMATCHED_OP = 3'd4;
  localparam logic [2:0] ERR_STACK_OVF    = 3'd5;
  localparam logic [2:0] ERR_PROG_FULL    = 3'd6;

endpackage

### hdl/bftm_ram.sv
module bftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/brainfuck_tape_machine.sv
// Clear, append, start and non-executing steps show their word the cycle after acceptance;
// an executed step shows it once ST_EXEC has acted on the registered memory reads, and a
// zero-cell open bracket first scans in ST_SCAN toward its matching close bracket. The receiver
// cannot stall and busy is low whenever a word is shown, so one word is taken per cycle while
// busy is low. Reset is synchronous and leaves the machine halted with an empty program; the
// tape is cleared lazily, a cell being zeroed when first reached.
module brainfuck_tape_machine #(
  parameter int TAPE_DEPTH    = bftm_pkg::DEF_TAPE_DEPTH,
  parameter int PROGRAM_DEPTH = bftm_pkg::DEF_PROGRAM_DEPTH,
  parameter int STACK_DEPTH   = bftm_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [7:0] instr_byte,
  input  logic [7:0] input_byte,
  output logic       done,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       input_used,
  output logic       halted,
  output logic [2:0] error_code
);

  import bftm_pkg::*;

  localparam int TW  = $clog2(TAPE_DEPTH);
  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int PW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN} state_t;

  state_t        state;
  logic [PW-1:0] length;
  logic [PW-1:0] position;
  logic [PW-1:0] scan_pos;
  logic [PW-1:0] scan_depth;
  logic [TW-1:0] ptr;
  logic [TW-1:0] maxp;
  logic [SCW-1:0] count;
  logic          halt_flag;
  logic [2:0]    last_error;
  logic [7:0]    in_byte;

  logic          accept;
  logic [7:0]    op;
  logic [7:0]    cell_byte;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] scan_inc;
  logic [PW-1:0] jmp_inc;
  logic [TW-1:0] ptr_inc;
  logic [SCW-1:0] count_dec;

  logic           tape_we;
  logic [TW-1:0]  tape_waddr;
  logic [7:0]     tape_wdata;
  logic [7:0]     tape_rdata;
  logic           prog_we;
  logic [PAW-1:0] prog_raddr;
  logic [7:0]     prog_rdata;
  logic           stack_we;
  logic [PAW-1:0] stack_rdata;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign halted     = halt_flag;
  assign error_code = last_error;
  assign op         = prog_rdata;
  assign cell_byte  = tape_rdata;
  assign pos_inc    = PW'(position + 1'b1);
  assign scan_inc   = PW'(scan_pos + 1'b1);
  assign jmp_inc    = PW'(PW'(stack_rdata) + 1'b1);
  assign ptr_inc    = TW'(ptr + 1'b1);
  assign count_dec  = SCW'(count - 1'b1);

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = ptr;
    tape_wdata = 8'd0;
    if (accept && command == CMD_START) begin
      tape_we    = 1'b1;
      tape_waddr = '0;
    end else if (state == ST_EXEC) begin
      case (op)
        OP_RIGHT: begin
          if (ptr != TW'(TAPE_DEPTH - 1) && ptr == maxp) begin
            tape_we    = 1'b1;
            tape_waddr = ptr_inc;
          end
        end
        OP_INC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_byte + 8'd1;
        end
        OP_DEC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_byte - 8'd1;
        end
        OP_IN: begin
          tape_we    = 1'b1;
          tape_wdata = in_byte;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prog_we  = accept && command == CMD_APPEND && length < PW'(PROGRAM_DEPTH);
    stack_we = state == ST_EXEC && op == OP_OPEN && cell_byte != 8'd0 &&
               count < SCW'(STACK_DEPTH);
    case (state)
      ST_EXEC: prog_raddr = pos_inc[PAW-1:0];
      ST_SCAN: prog_raddr = scan_inc[PAW-1:0];
      default: prog_raddr = position[PAW-1:0];
    endcase
  end

  bftm_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (ptr),
    .rdata (tape_rdata)
  );

  bftm_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (length[PAW-1:0]),
    .wdata (instr_byte),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  bftm_ram #(.WIDTH(PAW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (count[SAW-1:0]),
    .wdata (position[PAW-1:0]),
    .raddr (count_dec[SAW-1:0]),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      length     <= '0;
      position   <= '0;
      ptr        <= '0;
      maxp       <= '0;
      count      <= '0;
      halt_flag  <= 1'b1;
      last_error <= ERR_NONE;
      done       <= 1'b0;
      out_valid  <= 1'b0;
      out_byte   <= 8'd0;
      input_used <= 1'b0;
    end else begin
      done       <= 1'b0;
      out_valid  <= 1'b0;
      out_byte   <= 8'd0;
      input_used <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            in_byte <= input_byte;
            done    <= 1'b1;
            case (command)
              CMD_CLEAR: begin
                length     <= '0;
                position   <= '0;
                last_error <= ERR_NONE;
                halt_flag  <= 1'b1;
              end
              CMD_APPEND: begin
                if (length >= PW'(PROGRAM_DEPTH)) begin
                  halt_flag  <= 1'b1;
                  last_error <= ERR_PROG_FULL;
                end else begin
                  length <= PW'(length + 1'b1);
                end
              end
              CMD_START: begin
                position   <= '0;
                ptr        <= '0;
                maxp       <= '0;
                count      <= '0;
                last_error <= ERR_NONE;
                halt_flag  <= 1'b0;
              end
              default: begin
                if (!halt_flag) begin
                  if (position >= length) begin
                    halt_flag <= 1'b1;
                  end else begin
                    done  <= 1'b0;
                    state <= ST_EXEC;
                  end
                end
              end
            endcase
          end
        end
        ST_EXEC: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          case (op)
            OP_RIGHT: begin
              if (ptr == TW'(TAPE_DEPTH - 1)) begin
                halt_flag  <= 1'b1;
                last_error <= ERR_PTR_HIGH;
              end else begin
                ptr <= ptr_inc;
                if (ptr == maxp) begin
                  maxp <= ptr_inc;
                end
                position <= pos_inc;
                if (pos_inc >= length) halt_flag <= 1'b1;
              end
            end
            OP_LEFT: begin
              if (ptr == '0) begin
                halt_flag  <= 1'b1;
                last_error <= ERR_PTR_LOW;
              end else begin
                ptr      <= TW'(ptr - 1'b1);
                position <= pos_inc;
                if (pos_inc >= length) halt_flag <= 1'b1;
              end
            end
            OP_OPEN: begin
              if (cell_byte == 8'd0) begin
                if (pos_inc >= length) begin
                  halt_flag  <= 1'b1;
                  last_error <= ERR_UNMATCHED_OP;
                end else begin
                  done       <= 1'b0;
                  scan_pos   <= pos_inc;
                  scan_depth <= PW'(1);
                  state      <= ST_SCAN;
                end
              end else if (count >= SCW'(STACK_DEPTH)) begin
                halt_flag  <= 1'b1;
                last_error <= ERR_STACK_OVF;
              end else begin
                count    <= SCW'(count + 1'b1);
                position <= pos_inc;
                if (pos_inc >= length) halt_flag <= 1'b1;
              end
            end
            OP_CLOSE: begin
              if (count == '0) begin
                halt_flag  <= 1'b1;
                last_error <= ERR_UNMATCHED_CL;
              end else if (cell_byte != 8'd0) begin
                position <= jmp_inc;
                if (jmp_inc >= length) halt_flag <= 1'b1;
              end else begin
                count    <= count_dec;
                position <= pos_inc;
                if (pos_inc >= length) halt_flag <= 1'b1;
              end
            end
            default: begin
              if (op == OP_OUT) begin
                out_valid <= 1'b1;
                out_byte  <= cell_byte;
              end
              if (op == OP_IN) begin
                input_used <= 1'b1;
              end
              position <= pos_inc;
              if (pos_inc >= length) halt_flag <= 1'b1;
            end
          endcase
        end
        ST_SCAN: begin
          if (op == OP_CLOSE && scan_depth == PW'(1)) begin
            done     <= 1'b1;
            state    <= ST_IDLE;
            position <= scan_inc;
            if (scan_inc >= length) halt_flag <= 1'b1;
          end else if (scan_inc >= length) begin
            done       <= 1'b1;
            state      <= ST_IDLE;
            halt_flag  <= 1'b1;
            last_error <= ERR_UNMATCHED_OP;
          end else begin
            scan_pos <= scan_inc;
            if (op == OP_OPEN) begin
              scan_depth <= PW'(scan_depth + 1'b1);
            end else if (op == OP_CLOSE) begin
              scan_depth <= PW'(scan_depth - 1'b1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("word shown while the sequencer is busy");

  a_ptr_init: assert property (@(posedge clk) disable iff (rst) ptr <= maxp)
    else $error("tape pointer beyond the zeroed region");

  a_pos_len: assert property (@(posedge clk) disable iff (rst) position <= length)
    else $error("program position beyond the program length");

  a_stack_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= SCW'(STACK_DEPTH))
    else $error("loop stack count beyond its depth");

  a_step_exec: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_STEP && !halt_flag && position < length) |=> busy && !done)
    else $error("runnable step did not enter execution");

endmodule
